FILE: hw/rtl/egc_pkg.sv
package egc_pkg;

   localparam int VALUE_WIDTH     = 32;
   localparam int TIME_PORT_WIDTH = 32;
   localparam int DECAY_WIDTH     = 24;
   localparam int MODE_WIDTH      = 2;

   localparam logic [DECAY_WIDTH-1:0] DECAY_RESET = 24'd16775606;

   typedef logic [MODE_WIDTH-1:0] mode_type;
   localparam mode_type MODE_READ_VALUE  = 2'd0;
   localparam mode_type MODE_SET_VALUE   = 2'd1;
   localparam mode_type MODE_SET_TARGET  = 2'd2;
   localparam mode_type MODE_READ_TARGET = 2'd3;

   // datapath operations, one per microcode step
   typedef logic [3:0] op_type;
   localparam op_type OP_NONE      = 4'd0;
   localparam op_type OP_LATCH     = 4'd1;
   localparam op_type OP_SETUP     = 4'd2;
   localparam op_type OP_MUL_ACC   = 4'd3;
   localparam op_type OP_ACC       = 4'd4;
   localparam op_type OP_SHIFT     = 4'd5;
   localparam op_type OP_MUL_SQ    = 4'd6;
   localparam op_type OP_SQUARE    = 4'd7;
   localparam op_type OP_DIFF      = 4'd8;
   localparam op_type OP_MUL_BLEND = 4'd9;
   localparam op_type OP_BLEND     = 4'd10;
   localparam op_type OP_EMIT      = 4'd11;

   typedef logic [2:0] cond_type;
   localparam cond_type C_NEVER     = 3'd0;
   localparam cond_type C_ALWAYS    = 3'd1;
   localparam cond_type C_NO_TAKE   = 3'd2;
   localparam cond_type C_NO_GLIDE  = 3'd3;
   localparam cond_type C_BIT_CLEAR = 3'd4;
   localparam cond_type C_N_DONE    = 3'd5;
   localparam cond_type C_OUT_BUSY  = 3'd6;

   typedef logic [3:0] pc_type;
   localparam pc_type PC_WAIT      = 4'd0;
   localparam pc_type PC_SETUP     = 4'd1;
   localparam pc_type PC_LOOP      = 4'd2;
   localparam pc_type PC_MUL_ACC   = 4'd3;
   localparam pc_type PC_ACC       = 4'd4;
   localparam pc_type PC_SHIFT     = 4'd5;
   localparam pc_type PC_MUL_SQ    = 4'd6;
   localparam pc_type PC_SQUARE    = 4'd7;
   localparam pc_type PC_DIFF      = 4'd8;
   localparam pc_type PC_MUL_BLEND = 4'd9;
   localparam pc_type PC_BLEND     = 4'd10;
   localparam pc_type PC_EMIT      = 4'd11;

   // hold: stay on this step while true; else jump when jump is true; else step on
   typedef struct packed {
      op_type   op;
      cond_type hold;
      cond_type jump;
      pc_type   target;
   } ctrl_word_type;

   typedef struct packed {
      logic glide;
      logic bit_set;
      logic last_bit;
   } flags_type;

   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type w;
      unique case (pc)
         PC_WAIT:      w = '{OP_LATCH,     C_NO_TAKE,  C_NEVER,     PC_WAIT};
         PC_SETUP:     w = '{OP_SETUP,     C_NEVER,    C_NO_GLIDE,  PC_EMIT};
         PC_LOOP:      w = '{OP_NONE,      C_NEVER,    C_BIT_CLEAR, PC_SHIFT};
         PC_MUL_ACC:   w = '{OP_MUL_ACC,   C_NEVER,    C_NEVER,     PC_WAIT};
         PC_ACC:       w = '{OP_ACC,       C_NEVER,    C_NEVER,     PC_WAIT};
         PC_SHIFT:     w = '{OP_SHIFT,     C_NEVER,    C_N_DONE,    PC_DIFF};
         PC_MUL_SQ:    w = '{OP_MUL_SQ,    C_NEVER,    C_NEVER,     PC_WAIT};
         PC_SQUARE:    w = '{OP_SQUARE,    C_NEVER,    C_ALWAYS,    PC_LOOP};
         PC_DIFF:      w = '{OP_DIFF,      C_NEVER,    C_NEVER,     PC_WAIT};
         PC_MUL_BLEND: w = '{OP_MUL_BLEND, C_NEVER,    C_NEVER,     PC_WAIT};
         PC_BLEND:     w = '{OP_BLEND,     C_NEVER,    C_NEVER,     PC_WAIT};
         PC_EMIT:      w = '{OP_EMIT,      C_OUT_BUSY, C_ALWAYS,    PC_WAIT};
         default:      w = '{OP_NONE,      C_NEVER,    C_ALWAYS,    PC_WAIT};
      endcase
      return w;
   endfunction

endpackage

FILE: hw/rtl/egc_datapath.sv
module egc_datapath import egc_pkg::*; #(
   parameter int TIME_WIDTH      = 32,
   parameter int DECAY_FRAC_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  op_type                     op,
   input  logic                       req_take,
   input  mode_type                   req_mode,
   input  logic [TIME_PORT_WIDTH-1:0] req_sample_time,
   input  logic [VALUE_WIDTH-1:0]     req_operand_value,
   input  logic                       csr_wr_en,
   input  logic [DECAY_WIDTH-1:0]     csr_wr_data,
   output flags_type                  flags,
   output logic [VALUE_WIDTH-1:0]     result
);

   localparam int MAG_WIDTH  = VALUE_WIDTH + 1;
   localparam int PROD_WIDTH = MAG_WIDTH + DECAY_FRAC_BITS;
   localparam int Q_WIDTH    = PROD_WIDTH + 1 - DECAY_FRAC_BITS;
   localparam logic [PROD_WIDTH:0] HALF = (PROD_WIDTH+1)'(1) << (DECAY_FRAC_BITS - 1);

   logic [DECAY_FRAC_BITS-1:0] decay_ff, decay_in;
   logic [VALUE_WIDTH-1:0]     value_ff, value_in;
   logic [VALUE_WIDTH-1:0]     target_ff, target_in;
   logic [TIME_WIDTH-1:0]      last_time_ff, last_time_in;
   mode_type                   mode_ff, mode_in;
   logic [TIME_WIDTH-1:0]      time_ff, time_in;
   logic [VALUE_WIDTH-1:0]     opnd_ff, opnd_in;
   logic [TIME_WIDTH-1:0]      n_ff, n_in;
   logic [DECAY_FRAC_BITS-1:0] base_ff, base_in;
   logic [DECAY_FRAC_BITS-1:0] acc_ff, acc_in;
   logic                       have_ff, have_in;
   logic                       neg_ff, neg_in;
   logic [MAG_WIDTH-1:0]       mag_ff, mag_in;
   logic [PROD_WIDTH-1:0]      prod_ff, prod_in;

   logic [MAG_WIDTH-1:0]       mul_x;
   logic [DECAY_FRAC_BITS-1:0] mul_y;
   logic [PROD_WIDTH:0]        rounded;
   logic [Q_WIDTH-1:0]         q;
   logic [DECAY_FRAC_BITS-1:0] pow_q;
   logic [MAG_WIDTH-1:0]       diff;
   logic [Q_WIDTH-1:0]         tgt_ext;
   logic [Q_WIDTH-1:0]         blend;
   logic                       glide;

   // one shared multiplier, registered before rounding
   always_comb begin
      unique case (op)
         OP_MUL_SQ: begin
            mul_x = MAG_WIDTH'(base_ff);
            mul_y = base_ff;
         end
         OP_MUL_BLEND: begin
            mul_x = mag_ff;
            mul_y = acc_ff;
         end
         default: begin
            mul_x = MAG_WIDTH'(acc_ff);
            mul_y = base_ff;
         end
      endcase
   end

   assign prod_in = PROD_WIDTH'(mul_x) * PROD_WIDTH'(mul_y);
   assign rounded = {1'b0, prod_ff} + HALF;
   assign q       = rounded[PROD_WIDTH:DECAY_FRAC_BITS];
   assign pow_q   = q[DECAY_FRAC_BITS-1:0];

   assign diff    = {value_ff[VALUE_WIDTH-1], value_ff} - {target_ff[VALUE_WIDTH-1], target_ff};
   assign tgt_ext = {{(Q_WIDTH-VALUE_WIDTH){target_ff[VALUE_WIDTH-1]}}, target_ff};
   assign blend   = neg_ff ? (tgt_ext - q) : (tgt_ext + q);

   assign glide = (mode_ff == MODE_READ_VALUE) && (time_ff > last_time_ff);

   assign flags.glide    = glide;
   assign flags.bit_set  = n_ff[0];
   assign flags.last_bit = (n_ff[TIME_WIDTH-1:1] == '0);

   always_comb begin
      unique case (mode_ff)
         MODE_READ_VALUE:  result = value_ff;
         MODE_SET_VALUE,
         MODE_SET_TARGET:  result = opnd_ff;
         MODE_READ_TARGET: result = target_ff;
         default:          result = value_ff;
      endcase
   end

   always_comb begin
      decay_in     = csr_wr_en ? DECAY_FRAC_BITS'(csr_wr_data) : decay_ff;
      value_in     = value_ff;
      target_in    = target_ff;
      last_time_in = last_time_ff;
      mode_in      = mode_ff;
      time_in      = time_ff;
      opnd_in      = opnd_ff;
      n_in         = n_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      have_in      = have_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      unique case (op)
         OP_LATCH: begin
            if (req_take) begin
               mode_in = req_mode;
               time_in = TIME_WIDTH'(req_sample_time);
               opnd_in = req_operand_value;
            end
         end
         OP_SETUP: begin
            if (mode_ff == MODE_SET_VALUE) value_in = opnd_ff;
            if (mode_ff == MODE_SET_TARGET) target_in = opnd_ff;
            if (glide) begin
               n_in         = time_ff - last_time_ff;
               base_in      = decay_ff;
               have_in      = 1'b0;
               last_time_in = time_ff;
            end
         end
         OP_ACC: begin
            acc_in  = have_ff ? pow_q : base_ff;
            have_in = 1'b1;
         end
         OP_SHIFT:  n_in = n_ff >> 1;
         OP_SQUARE: base_in = pow_q;
         OP_DIFF: begin
            neg_in = diff[MAG_WIDTH-1];
            mag_in = diff[MAG_WIDTH-1] ? (~diff + MAG_WIDTH'(1)) : diff;
         end
         OP_BLEND:  value_in = blend[VALUE_WIDTH-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff     <= DECAY_FRAC_BITS'(DECAY_RESET);
         value_ff     <= '0;
         target_ff    <= '0;
         last_time_ff <= '0;
      end else begin
         decay_ff     <= decay_in;
         value_ff     <= value_in;
         target_ff    <= target_in;
         last_time_ff <= last_time_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      time_ff <= time_in;
      opnd_ff <= opnd_in;
      n_ff    <= n_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      have_ff <= have_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
   end

endmodule

FILE: hw/rtl/exponential_glide_curve_top.sv
// channel   ports                                               direction
// req       req_valid req_stall req_mode req_sample_time         in (stall out)
//           req_operand_value
// rsp       rsp_valid rsp_stall rsp_result_value                 out (stall in)
// csr       csr_wr_en csr_wr_data                                in
//
// A microcoded sequencer drives one shared multiplier; a word with no glide due
// goes from setup straight to emit, else the square-and-multiply loop runs over
// the bits of the elapsed sample count before the blend.
// Reset (synchronous) clears value, target and last time, and loads the default decay.
// The next word is taken while a finished result is still held on a stalled rsp.
module exponential_glide_curve_top import egc_pkg::*; #(
   parameter int TIME_WIDTH      = 32,
   parameter int DECAY_FRAC_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [MODE_WIDTH-1:0]             req_mode,
   input  logic [TIME_PORT_WIDTH-1:0]        req_sample_time,
   input  logic signed [VALUE_WIDTH-1:0]     req_operand_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]     rsp_result_value,
   input  logic                              csr_wr_en,
   input  logic [DECAY_WIDTH-1:0]            csr_wr_data
);

   pc_type                 pc_ff, pc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   ctrl_word_type          ctrl;
   flags_type              flags;
   logic [VALUE_WIDTH-1:0] result;
   logic                   req_take;
   logic                   out_busy;
   logic                   emit_go;
   logic                   hold_now;
   logic                   jump_now;

   function automatic logic cond_true(input cond_type c, input flags_type f,
                                      input logic take, input logic busy);
      logic r;
      unique case (c)
         C_NEVER:     r = 1'b0;
         C_ALWAYS:    r = 1'b1;
         C_NO_TAKE:   r = !take;
         C_NO_GLIDE:  r = !f.glide;
         C_BIT_CLEAR: r = !f.bit_set;
         C_N_DONE:    r = f.last_bit;
         C_OUT_BUSY:  r = busy;
         default:     r = 1'b0;
      endcase
      return r;
   endfunction

   assign ctrl      = ucode_rom(pc_ff);
   assign req_stall = (pc_ff != PC_WAIT);
   assign req_take  = req_valid && !req_stall;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign emit_go   = (ctrl.op == OP_EMIT) && !out_busy;
   assign hold_now  = cond_true(ctrl.hold, flags, req_take, out_busy);
   assign jump_now  = cond_true(ctrl.jump, flags, req_take, out_busy);

   egc_datapath #(
      .TIME_WIDTH      (TIME_WIDTH),
      .DECAY_FRAC_BITS (DECAY_FRAC_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .op                (ctrl.op),
      .req_take          (req_take),
      .req_mode          (req_mode),
      .req_sample_time   (req_sample_time),
      .req_operand_value (req_operand_value),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .flags             (flags),
      .result            (result)
   );

   always_comb begin
      priority if (hold_now) pc_in = pc_ff;
      else if (jump_now)     pc_in = ctrl.target;
      else                   pc_in = pc_ff + pc_type'(1);
   end

   // output word register frees the sequencer from a stalled consumer
   assign rsp_valid_in = emit_go ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   assign rsp_value_in = emit_go ? result : rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

   a_take_to_setup: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (pc_ff == PC_SETUP))
      else $error("accepted word did not move to setup");

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_EMIT)
      else $error("step counter left the program");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (rsp_valid && (pc_ff == PC_WAIT)))
      else $error("emit did not present a word and return to wait");

endmodule
